FILE: sv/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; imported by bgc_chan_update and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bgc_pkg;

    // Event codes on the result channel
    typedef enum logic [2:0] {
        EV_ON                = 3'd0,
        EV_OFF               = 3'd1,
        EV_SHORT             = 3'd2,
        EV_LONG              = 3'd3,
        EV_SHORT_LONG        = 3'd4,
        EV_LONG_REPEAT       = 3'd5,
        EV_SHORT_LONG_REPEAT = 3'd6,
        EV_DOUBLE            = 3'd7
    } ev_kind_t;

    // Configuration register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_LONG_DELAY    = 3'd1,
        REG_REPEAT_DELAY  = 3'd2,
        REG_DOUBLE_WINDOW = 3'd3,
        REG_DOUBLE_ENABLE = 3'd4
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    // Timing configuration seen by the channel update logic
    typedef struct packed {
        logic [15:0] long_delay;
        logic [15:0] repeat_delay;
        logic [15:0] double_window;
        logic        double_enable;
    } cfg_t;

    // Per-channel flag bits kept in the state memory
    typedef struct packed {
        logic level;
        logic long_flag;
        logic double_flag;
        logic lt_active;
        logic dt_active;
    } chan_flags_t;

    // Events produced by one channel update, in order
    localparam int unsigned EV_SLOTS = 3;

    typedef struct packed {
        logic [1:0]                  count;
        ev_kind_t [EV_SLOTS-1:0]     kind;
    } upd_ev_t;

    // Result cap per input transaction
    localparam int unsigned CNT_W       = 5;
    localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

endpackage

`default_nettype wire

FILE: sv/bgc_chan_update.sv
// Read-modify-write logic for one channel entry: edge or tick handling.
// Depends on bgc_pkg for the config, flag and event types.
`timescale 1ns / 1ps
`default_nettype none

module bgc_chan_update #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                   is_tick,
    input  wire logic                   level_in,
    input  wire bgc_pkg::cfg_t          cfg,
    input  wire bgc_pkg::chan_flags_t   flags_in,
    input  wire logic [TIMER_BITS-1:0]  lt_cnt_in,
    input  wire logic [TIMER_BITS-1:0]  dt_cnt_in,
    output bgc_pkg::chan_flags_t        flags_out,
    output logic [TIMER_BITS-1:0]       lt_cnt_out,
    output logic [TIMER_BITS-1:0]       dt_cnt_out,
    output bgc_pkg::upd_ev_t            events
);
    import bgc_pkg::*;

    localparam int EXT_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] T_MAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

    // Saturate a 16-bit load value to the timer width
    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [15:0] v);
        logic [EXT_W-1:0] v_ext;
        logic [EXT_W-1:0] m_ext;
        v_ext = EXT_W'(v);
        m_ext = EXT_W'(T_MAX);
        if (v_ext > m_ext) begin
            sat_load = T_MAX;
        end else begin
            sat_load = TIMER_BITS'(v_ext);
        end
    endfunction

    logic [TIMER_BITS-1:0] long_load;
    logic [TIMER_BITS-1:0] rep_load;
    logic [TIMER_BITS-1:0] win_load;
    logic                  dbl;

    assign long_load = sat_load(cfg.long_delay);
    assign rep_load  = sat_load(cfg.repeat_delay);
    assign win_load  = sat_load(cfg.double_window);
    assign dbl       = cfg.double_enable & flags_in.double_flag;

    // Apply an edge or one tick to the entry and list the events in order
    always_comb begin
        logic [1:0] n;
        n          = 2'd0;
        flags_out  = flags_in;
        lt_cnt_out = lt_cnt_in;
        dt_cnt_out = dt_cnt_in;
        events     = '0;
        if (!is_tick) begin
            flags_out.level = level_in;
            if (level_in) begin
                // press: arm long timer, latch whether a second press is in the window
                flags_out.lt_active = 1'b1;
                lt_cnt_out          = long_load;
                if (cfg.double_enable) begin
                    flags_out.double_flag = flags_in.dt_active;
                end
                events.kind[n] = EV_ON;
                n              = n + 2'd1;
            end else begin
                // release: short/double decision, then stop the long timer
                if (!flags_in.long_flag) begin
                    if (cfg.double_enable) begin
                        if (flags_in.double_flag || (cfg.double_window == 16'd0)) begin
                            flags_out.dt_active = 1'b0;
                            dt_cnt_out          = '0;
                            events.kind[n] = flags_in.double_flag ? EV_DOUBLE : EV_SHORT;
                            n              = n + 2'd1;
                        end else begin
                            flags_out.dt_active = 1'b1;
                            dt_cnt_out          = win_load;
                        end
                    end else begin
                        events.kind[n] = EV_SHORT;
                        n              = n + 2'd1;
                    end
                end
                flags_out.lt_active = 1'b0;
                flags_out.long_flag = 1'b0;
                lt_cnt_out          = '0;
                events.kind[n]      = EV_OFF;
                n                   = n + 2'd1;
            end
        end else begin
            // long/repeat timer first
            if (flags_in.lt_active) begin
                if (lt_cnt_in <= T_ONE) begin
                    flags_out.lt_active = 1'b0;
                    lt_cnt_out          = '0;
                    if (!flags_in.long_flag) begin
                        flags_out.long_flag = 1'b1;
                        events.kind[n]      = dbl ? EV_SHORT_LONG : EV_LONG;
                        n                   = n + 2'd1;
                    end
                    if (cfg.repeat_delay != 16'd0) begin
                        events.kind[n] = dbl ? EV_SHORT_LONG_REPEAT : EV_LONG_REPEAT;
                        n              = n + 2'd1;
                        flags_out.lt_active = 1'b1;
                        lt_cnt_out          = rep_load;
                    end
                end else begin
                    lt_cnt_out = lt_cnt_in - T_ONE;
                end
            end
            // then the double-click timer
            if (flags_in.dt_active) begin
                if (dt_cnt_in <= T_ONE) begin
                    flags_out.dt_active = 1'b0;
                    dt_cnt_out          = '0;
                    if (!flags_in.level) begin
                        events.kind[n] = flags_in.double_flag ? EV_DOUBLE : EV_SHORT;
                        n              = n + 2'd1;
                    end
                end else begin
                    dt_cnt_out = dt_cnt_in - T_ONE;
                end
            end
        end
        events.count = n;
    end

endmodule

`default_nettype wire

FILE: sv/button_gesture_classifier_unit.sv
// An accepted edge reads its channel entry, updates it and writes it back (ST_EXEC), stages
// each event in a pending slot (ST_EMIT), waiting for room in the output register, and
// releases the last one in ST_FLUSH; a tick walks every channel in turn the same way.
// One item at a time; the input is ready only between items.
// Reset (synchronous, aresetn low) clears per-entry valid bits at once, so every
// channel reads as all zero; config returns to its documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_classifier_unit #(
    parameter int CHANNELS   = 8,
    parameter int TIMER_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input transactions
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [2:0]  s_channel,
    input  wire logic        s_level,
    // result transactions
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_channel,
    output logic [2:0]       m_event_kind,
    output logic             m_last
);
    import bgc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FLG_W = $bits(chan_flags_t);
    localparam int ENT_W = FLG_W + 2 * TIMER_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
    localparam logic [5:0]       CH_LIM   = 6'(CHANNELS);

    // ---------------- configuration registers ----------------
    logic [3:0]  channel_count_reg;
    logic [15:0] long_delay_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] double_window_reg;
    logic        double_enable_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    cfg_t        cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    // Write a register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= 4'd8;
            long_delay_reg    <= 16'd1000;
            repeat_delay_reg  <= 16'd0;
            double_window_reg <= 16'd300;
            double_enable_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[3:0];
                REG_LONG_DELAY:    long_delay_reg    <= pwdata[15:0];
                REG_REPEAT_DELAY:  repeat_delay_reg  <= pwdata[15:0];
                REG_DOUBLE_WINDOW: double_window_reg <= pwdata[15:0];
                REG_DOUBLE_ENABLE: double_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (cfg_idx)
            REG_CHANNEL_COUNT: prdata = {28'd0, channel_count_reg};
            REG_LONG_DELAY:    prdata = {16'd0, long_delay_reg};
            REG_REPEAT_DELAY:  prdata = {16'd0, repeat_delay_reg};
            REG_DOUBLE_WINDOW: prdata = {16'd0, double_window_reg};
            REG_DOUBLE_ENABLE: prdata = {31'd0, double_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.long_delay    = long_delay_reg;
    assign cfg.repeat_delay  = repeat_delay_reg;
    assign cfg.double_window = double_window_reg;
    assign cfg.double_enable = double_enable_reg;

    // Effective channel count and range check on edges
    logic [5:0] count_ext;
    logic [5:0] eff_count;
    logic       ch_ok;

    assign count_ext = {2'd0, channel_count_reg};
    assign eff_count = (count_ext > CH_LIM) ? CH_LIM : count_ext;
    assign ch_ok     = ({3'd0, s_channel} < eff_count);

    // ---------------- control registers ----------------
    state_t                  state_reg, state_next;
    logic                    is_tick_reg, is_tick_next;
    logic                    lvl_reg, lvl_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    upd_ev_t                 ev_reg, ev_next;
    logic [1:0]              ev_idx_reg, ev_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    ev_kind_t                pend_kind_reg, pend_kind_next;
    logic [2:0]              pend_ch_reg, pend_ch_next;
    logic [CNT_W-1:0]        ev_count_reg, ev_count_next;

    // ---------------- state memory ----------------
    logic [ENT_W-1:0]        mem [CHANNELS];
    logic [CHANNELS-1:0]     ent_valid_reg;
    logic [ENT_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [ENT_W-1:0]        wr_data;
    logic [ENT_W-1:0]        rd_ent;

    // Write-back and registered read; the sequencer never reads an entry in the
    // cycle it is written, so no forwarding path is needed.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits: an unwritten entry reads as all zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                ent_valid_reg[idx_reg] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= ent_valid_reg[rd_addr];
            end
        end
    end

    assign rd_ent = rd_valid_reg ? rd_data_reg : '0;

    // ---------------- channel update ----------------
    chan_flags_t             upd_flags;
    logic [TIMER_BITS-1:0]   upd_lt;
    logic [TIMER_BITS-1:0]   upd_dt;
    upd_ev_t                 upd_ev;

    bgc_chan_update #(
        .TIMER_BITS (TIMER_BITS)
    ) u_update (
        .is_tick    (is_tick_reg),
        .level_in   (lvl_reg),
        .cfg        (cfg),
        .flags_in   (chan_flags_t'(rd_ent[ENT_W-1 -: FLG_W])),
        .lt_cnt_in  (rd_ent[2*TIMER_BITS-1 -: TIMER_BITS]),
        .dt_cnt_in  (rd_ent[TIMER_BITS-1:0]),
        .flags_out  (upd_flags),
        .lt_cnt_out (upd_lt),
        .dt_cnt_out (upd_dt),
        .events     (upd_ev)
    );

    assign wr_data = {upd_flags, upd_lt, upd_dt};

    // ---------------- output register ----------------
    logic     m_valid_reg;
    logic     out_free;
    logic     push;
    logic     push_last;
    ev_kind_t m_kind_reg;
    logic [2:0] m_ch_reg;
    logic     m_last_reg;

    assign out_free = ~m_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload from the pending slot
    always_ff @(posedge aclk) begin
        if (push) begin
            m_kind_reg <= pend_kind_reg;
            m_ch_reg   <= pend_ch_reg;
            m_last_reg <= push_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_channel = m_ch_reg;
    assign m_event_kind    = m_kind_reg;
    assign m_last          = m_last_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            ev_count_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            ev_count_reg   <= ev_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_tick_reg   <= is_tick_next;
        lvl_reg       <= lvl_next;
        idx_reg       <= idx_next;
        ev_reg        <= ev_next;
        ev_idx_reg    <= ev_idx_next;
        pend_kind_reg <= pend_kind_next;
        pend_ch_reg   <= pend_ch_next;
    end

    // Next state, memory accesses and event hand-off
    always_comb begin
        logic advance;
        logic step;
        ev_kind_t cur_kind;
        advance         = 1'b0;
        step            = 1'b0;
        cur_kind        = ev_reg.kind[ev_idx_reg];
        state_next      = state_reg;
        is_tick_next    = is_tick_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        ev_next         = ev_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_ch_next    = pend_ch_reg;
        ev_count_next   = ev_count_reg;
        s_ready         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + IDX_W'(1);
        wr_en           = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    is_tick_next = s_func;
                    lvl_next     = s_level;
                    if (s_func) begin
                        // tick: walk from channel 0
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_EXEC;
                    end else if (ch_ok) begin
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(s_channel);
                        idx_next   = IDX_W'(s_channel);
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                // entry data is ready: modify and write back
                wr_en       = 1'b1;
                ev_next     = upd_ev;
                ev_idx_next = 2'd0;
                if (upd_ev.count != 2'd0) begin
                    state_next = ST_EMIT;
                end else begin
                    advance = 1'b1;
                end
            end

            ST_EMIT: begin
                if (ev_count_reg == MAX_RESULTS) begin
                    // drop results past the cap
                    step = 1'b1;
                end else if (!pend_valid_reg || out_free) begin
                    step            = 1'b1;
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_kind_next  = cur_kind;
                    pend_ch_next    = 3'(idx_reg);
                    ev_count_next   = ev_count_reg + CNT_W'(1);
                end
                if (step) begin
                    if (ev_idx_reg == ev_reg.count - 2'd1) begin
                        advance = 1'b1;
                    end else begin
                        ev_idx_next = ev_idx_reg + 2'd1;
                    end
                end
            end

            ST_FLUSH: begin
                // release the held event as the final one
                if (!pend_valid_reg) begin
                    ev_count_next = '0;
                    state_next    = ST_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    ev_count_next   = '0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Move to the next channel of a tick, or finish
        if (advance) begin
            if (is_tick_reg && (idx_reg != LAST_IDX)) begin
                rd_en      = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_EXEC;
            end else begin
                state_next = ST_FLUSH;
            end
        end
    end

    // ---------------- assertions ----------------
    a_clean_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!pend_valid_reg && (ev_count_reg == '0)))
        else $error("input accepted with events of a previous transaction pending");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_count_reg <= MAX_RESULTS)
        else $error("event count above the cap");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_last) |=> (!pend_valid_reg && (state_reg == ST_IDLE)))
        else $error("final result pushed while the transaction is still active");

    a_wr_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> ent_valid_reg[$past(idx_reg)])
        else $error("written entry not marked valid");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (out_free && pend_valid_reg))
        else $error("result pushed into a full output register");

endmodule

`default_nettype wire
